// File: sv/ipbt_pkg.sv
// ----------------------------------------------------------------------------
// ipbt_pkg
// shared types for the ipv4 ban table: action and status codes, compare flags
// ----------------------------------------------------------------------------
package ipbt_pkg;

    localparam int IP_W = 32;

    typedef enum logic [1:0] {
        ACT_BAN_ADDR    = 2'd0,
        ACT_BAN_RANGE   = 2'd1,
        ACT_UNBAN_RANGE = 2'd2,
        ACT_CHECK_ADDR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // flags from the shared compare unit for one entry of each table
    typedef struct packed {
        logic addr_eq;
        logic range_eq;
        logic in_range;
    } cmp_res_t;

endpackage

// File: sv/ipbt_ram.sv
// ----------------------------------------------------------------------------
// ipbt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ipbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/ipbt_cmp.sv
// ----------------------------------------------------------------------------
// ipbt_cmp
// shared compare unit: matches the held key against one entry of each table
// ----------------------------------------------------------------------------
module ipbt_cmp import ipbt_pkg::*; (
    input  logic [IP_W-1:0] key_addr,
    input  logic [IP_W-1:0] key_lo,
    input  logic [IP_W-1:0] key_hi,
    input  logic [IP_W-1:0] entry_addr,
    input  logic [IP_W-1:0] entry_lo,
    input  logic [IP_W-1:0] entry_hi,
    output cmp_res_t        res
);

    always_comb
    begin
        res.addr_eq  = (key_addr == entry_addr);
        res.range_eq = (key_lo == entry_lo) && (key_hi == entry_hi);
        // an inverted range never contains anything
        res.in_range = (entry_lo <= key_addr) && (key_addr <= entry_hi);
    end

endmodule

// File: sv/ip_ban_table.sv
// ----------------------------------------------------------------------------
// ip_ban_table
// ipv4 blocklist with a table of single addresses and a table of ranges
// ----------------------------------------------------------------------------
//  channel  dir  word fields (lowest bit first)
//  s_axis   in   tdata: addr[31:0], range_low[63:32], range_high[95:64]
//                tuser: action[1:0]
//  m_axis   out  tdata: status[1:0], banned[2], zero pad [7:3]
//
//  a word is scanned one entry a cycle through both table rams and the shared
//  compare unit over the longer table, then passes the drain and done states
//  before the next word can be accepted
//  s_axis_tready is high only while idle; m_axis holds its word in a register
//  and a finished result waits in the done state while that register is full
//  reset clears all valid bits at once, so the tables start empty with no sweep
// ----------------------------------------------------------------------------
module ip_ban_table import ipbt_pkg::*; #(
    parameter int ADDR_ENTRIES  = 64,
    parameter int RANGE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // addr, range_low, range_high
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status, banned, pad
);

    localparam int A_AW     = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;
    localparam int R_AW     = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int SCAN_LEN = (ADDR_ENTRIES > RANGE_ENTRIES) ? ADDR_ENTRIES : RANGE_ENTRIES;
    localparam int CNT_W    = $clog2(SCAN_LEN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    // control state
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         idx_d_reg, idx_d_next;
    logic                     a_pend_reg, a_pend_next;
    logic                     r_pend_reg, r_pend_next;
    logic                     a_hit_reg, a_hit_next;
    logic                     a_free_found_reg, a_free_found_next;
    logic [A_AW-1:0]          a_free_idx_reg, a_free_idx_next;
    logic                     r_eq_found_reg, r_eq_found_next;
    logic [R_AW-1:0]          r_eq_idx_reg, r_eq_idx_next;
    logic                     r_in_reg, r_in_next;
    logic                     r_free_found_reg, r_free_found_next;
    logic [R_AW-1:0]          r_free_idx_reg, r_free_idx_next;
    logic [ADDR_ENTRIES-1:0]  addr_valid_reg, addr_valid_next;
    logic [RANGE_ENTRIES-1:0] range_valid_reg, range_valid_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    // payload
    action_t                  act_reg, act_next;
    logic [IP_W-1:0]          key_addr_reg, key_addr_next;
    logic [IP_W-1:0]          key_lo_reg, key_lo_next;
    logic [IP_W-1:0]          key_hi_reg, key_hi_next;
    status_t                  res_status_reg, res_status_next;
    logic                     res_banned_reg, res_banned_next;

    // table access
    logic                     a_we, r_we, r_clr;
    logic [IP_W-1:0]          a_rdata;
    logic [2*IP_W-1:0]        r_rdata;
    logic                     a_slot_v, r_slot_v;
    logic                     out_free;
    cmp_res_t                 cmp;

    ipbt_ram #(
        .WIDTH (IP_W),
        .DEPTH (ADDR_ENTRIES)
    ) u_addr_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_free_idx_reg),
        .wdata (key_addr_reg),
        .raddr (cnt_reg[A_AW-1:0]),
        .rdata (a_rdata)
    );

    // range entries hold the low bound in the lower half
    ipbt_ram #(
        .WIDTH (2*IP_W),
        .DEPTH (RANGE_ENTRIES)
    ) u_range_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_free_idx_reg),
        .wdata ({key_hi_reg, key_lo_reg}),
        .raddr (cnt_reg[R_AW-1:0]),
        .rdata (r_rdata)
    );

    ipbt_cmp u_cmp (
        .key_addr   (key_addr_reg),
        .key_lo     (key_lo_reg),
        .key_hi     (key_hi_reg),
        .entry_addr (a_rdata),
        .entry_lo   (r_rdata[IP_W-1:0]),
        .entry_hi   (r_rdata[2*IP_W-1:IP_W]),
        .res        (cmp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {5'd0, res_banned_reg, res_status_reg};

    // valid bits of the entry whose ram data is being compared
    assign a_slot_v = addr_valid_reg[idx_d_reg[A_AW-1:0]];
    assign r_slot_v = range_valid_reg[idx_d_reg[R_AW-1:0]];
    assign out_free = !m_tvalid_reg || m_axis_tready;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        idx_d_next        = idx_d_reg;
        a_pend_next       = 1'b0;
        r_pend_next       = 1'b0;
        a_hit_next        = a_hit_reg;
        a_free_found_next = a_free_found_reg;
        a_free_idx_next   = a_free_idx_reg;
        r_eq_found_next   = r_eq_found_reg;
        r_eq_idx_next     = r_eq_idx_reg;
        r_in_next         = r_in_reg;
        r_free_found_next = r_free_found_reg;
        r_free_idx_next   = r_free_idx_reg;
        addr_valid_next   = addr_valid_reg;
        range_valid_next  = range_valid_reg;
        m_tvalid_next     = m_tvalid_reg && !m_axis_tready;
        act_next          = act_reg;
        key_addr_next     = key_addr_reg;
        key_lo_next       = key_lo_reg;
        key_hi_next       = key_hi_reg;
        res_status_next   = res_status_reg;
        res_banned_next   = res_banned_reg;
        a_we              = 1'b0;
        r_we              = 1'b0;
        r_clr             = 1'b0;

        // compare stage, in the cycle after the ram read
        if (a_pend_reg)
        begin
            if (a_slot_v && cmp.addr_eq)
            begin
                a_hit_next = 1'b1;
            end
            if (!a_slot_v && !a_free_found_reg)
            begin
                a_free_found_next = 1'b1;
                a_free_idx_next   = idx_d_reg[A_AW-1:0];
            end
        end
        if (r_pend_reg)
        begin
            if (r_slot_v && cmp.range_eq && !r_eq_found_reg)
            begin
                r_eq_found_next = 1'b1;
                r_eq_idx_next   = idx_d_reg[R_AW-1:0];
            end
            if (r_slot_v && cmp.in_range)
            begin
                r_in_next = 1'b1;
            end
            if (!r_slot_v && !r_free_found_reg)
            begin
                r_free_found_next = 1'b1;
                r_free_idx_next   = idx_d_reg[R_AW-1:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next          = action_t'(s_axis_tuser);
                    key_addr_next     = s_axis_tdata[IP_W-1:0];
                    key_lo_next       = s_axis_tdata[2*IP_W-1:IP_W];
                    key_hi_next       = s_axis_tdata[3*IP_W-1:2*IP_W];
                    cnt_next          = '0;
                    a_hit_next        = 1'b0;
                    a_free_found_next = 1'b0;
                    r_eq_found_next   = 1'b0;
                    r_in_next         = 1'b0;
                    r_free_found_next = 1'b0;
                    state_next        = S_SCAN;
                end
            end
            S_SCAN:
            begin
                a_pend_next = (cnt_reg < CNT_W'(ADDR_ENTRIES));
                r_pend_next = (cnt_reg < CNT_W'(RANGE_ENTRIES));
                idx_d_next  = cnt_reg;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SCAN_LEN - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_status_next = ST_OK;
                    res_banned_next = 1'b0;
                    case (act_reg)
                        ACT_BAN_ADDR:
                        begin
                            // a duplicate wins over a full table
                            if (a_hit_reg)
                            begin
                                res_status_next = ST_DUP;
                            end
                            else if (!a_free_found_reg)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                a_we = 1'b1;
                                addr_valid_next[a_free_idx_reg] = 1'b1;
                            end
                        end
                        ACT_BAN_RANGE:
                        begin
                            if (r_eq_found_reg)
                            begin
                                res_status_next = ST_DUP;
                            end
                            else if (!r_free_found_reg)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                r_we = 1'b1;
                                range_valid_next[r_free_idx_reg] = 1'b1;
                            end
                        end
                        ACT_UNBAN_RANGE:
                        begin
                            if (r_eq_found_reg)
                            begin
                                r_clr = 1'b1;
                                range_valid_next[r_eq_idx_reg] = 1'b0;
                            end
                            else
                            begin
                                res_status_next = ST_DUP;
                            end
                        end
                        ACT_CHECK_ADDR:
                        begin
                            res_banned_next = a_hit_reg || r_in_reg;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            idx_d_reg        <= '0;
            a_pend_reg       <= 1'b0;
            r_pend_reg       <= 1'b0;
            a_hit_reg        <= 1'b0;
            a_free_found_reg <= 1'b0;
            a_free_idx_reg   <= '0;
            r_eq_found_reg   <= 1'b0;
            r_eq_idx_reg     <= '0;
            r_in_reg         <= 1'b0;
            r_free_found_reg <= 1'b0;
            r_free_idx_reg   <= '0;
            addr_valid_reg   <= '0;
            range_valid_reg  <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            idx_d_reg        <= idx_d_next;
            a_pend_reg       <= a_pend_next;
            r_pend_reg       <= r_pend_next;
            a_hit_reg        <= a_hit_next;
            a_free_found_reg <= a_free_found_next;
            a_free_idx_reg   <= a_free_idx_next;
            r_eq_found_reg   <= r_eq_found_next;
            r_eq_idx_reg     <= r_eq_idx_next;
            r_in_reg         <= r_in_next;
            r_free_found_reg <= r_free_found_next;
            r_free_idx_reg   <= r_free_idx_next;
            addr_valid_reg   <= addr_valid_next;
            range_valid_reg  <= range_valid_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        key_addr_reg   <= key_addr_next;
        key_lo_reg     <= key_lo_next;
        key_hi_reg     <= key_hi_next;
        res_status_reg <= res_status_next;
        res_banned_reg <= res_banned_next;
    end

    // a successful address ban adds exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        a_we |=> $countones(addr_valid_reg) == $past($countones(addr_valid_reg)) + 1)
        else $error("address ban did not add one entry");

    // a successful unban removes exactly one range
    assert property (@(posedge clk) disable iff (!rst_n)
        r_clr |=> $countones(range_valid_reg) + 1 == $past($countones(range_valid_reg)))
        else $error("range unban did not remove one entry");

    // a banned flag only comes with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && res_banned_reg) |-> (res_status_reg == ST_OK))
        else $error("banned result with non-ok status");

    // the scan index never runs past the longer table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg < CNT_W'(SCAN_LEN)))
        else $error("scan index out of range");

endmodule
